@@ rtl/core/sparse_adjacency_edge_insert_macros.svh @@
// ---------------------------------------------------------------------------
// sparse adjacency edge insert assertion macros
// concurrent checks, compiled out when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef SPARSE_ADJACENCY_EDGE_INSERT_MACROS_SVH
`define SPARSE_ADJACENCY_EDGE_INSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every edge out of reset
`define SAE_ASSERT(lbl, clk_sig, rstn_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("sae check failed");

// checked on every edge, reset included
`define SAE_ASSERT_ALWAYS(lbl, clk_sig, prop) \
    lbl: assert property (@(posedge clk_sig) prop) \
        else $error("sae check failed");

`else

`define SAE_ASSERT(lbl, clk_sig, rstn_sig, prop)
`define SAE_ASSERT_ALWAYS(lbl, clk_sig, prop)

`endif

`endif

@@ rtl/core/sae_pkg.sv @@
// ---------------------------------------------------------------------------
// sae_pkg
// sizes, types and controller/datapath interface of the edge insert block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sae_pkg;

    localparam int NODE_COUNT    = 256;
    localparam int EDGE_CAPACITY = 1024;
    localparam int LABEL_WIDTH   = 32;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int EDGE_W = $clog2(EDGE_CAPACITY);
    localparam int CNT_W  = $clog2(EDGE_CAPACITY + 1);
    localparam int COL_W  = 8;

    typedef logic [NODE_W-1:0]             node_t;
    typedef logic [EDGE_W-1:0]             edge_idx_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic [COL_W-1:0]              col_t;
    typedef logic signed [LABEL_WIDTH-1:0] label_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // latch the accepted beat
        logic set_full;    // drop item, store is full
        logic new_row;     // first edge of an empty row, self linked
        logic rd_tail;     // read row tail pointer
        logic set_tail;    // read tail edge, prev becomes tail
        logic take_link;   // new edge links to tail's successor, append at tail
        logic walk_read;   // read the successor edge
        logic advance;     // prev moves to the edge just compared
        logic take_cur;    // new edge links to the edge just compared
        logic merge;       // add label into the edge just compared
        logic write_new;   // write new edge slot
        logic write_prev;  // relink prev to new edge, bump count
        logic emit;        // load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic nonempty;
        logic ordered;
        logic col_gt;
        logic col_lt;
        logic col_eq;
        logic out_free;
    } status_t;

endpackage

@@ rtl/core/sae_ctrl.sv @@
// ---------------------------------------------------------------------------
// sae_ctrl
// sequencer for one edge insert: check, tail lookup, list walk, relink
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_adjacency_edge_insert_macros.svh"

module sae_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sae_pkg::status_t  status,
    output sae_pkg::cmd_t     cmd
);
    import sae_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TAIL_RD,
        ST_TAIL_COL,
        ST_WALK_CMP,
        ST_LINK_NEW,
        ST_LINK_PREV,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg, in_stall_next;
    logic   accept;
    logic   result_wait;

    assign accept      = in_valid && !in_stall_reg;
    assign in_stall    = in_stall_reg;
    assign result_wait = (state_reg == ST_RESULT) && !status.out_free;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_stall_next = in_stall_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    in_stall_next = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_RESULT;
                end
                else if (!status.nonempty)
                begin
                    cmd.new_row = 1'b1;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    cmd.rd_tail = 1'b1;
                    state_next  = ST_TAIL_RD;
                end
            end
            ST_TAIL_RD:
            begin
                cmd.set_tail = 1'b1;
                state_next   = ST_TAIL_COL;
            end
            ST_TAIL_COL:
            begin
                if (!status.ordered || status.col_gt)
                begin
                    cmd.take_link = 1'b1;
                    state_next    = ST_LINK_NEW;
                end
                else
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = ST_WALK_CMP;
                end
            end
            ST_WALK_CMP:
            begin
                if (status.col_lt)
                begin
                    cmd.take_cur = 1'b1;
                    state_next   = ST_LINK_NEW;
                end
                else if (status.col_eq)
                begin
                    cmd.merge  = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.advance   = 1'b1;
                    cmd.walk_read = 1'b1;
                end
            end
            ST_LINK_NEW:
            begin
                cmd.write_new = 1'b1;
                state_next    = ST_LINK_PREV;
            end
            ST_LINK_PREV:
            begin
                cmd.write_prev = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    in_stall_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    `SAE_ASSERT(a_ready_only_idle, clk, rst_n, !in_stall_reg |-> state_reg == ST_IDLE)
    `SAE_ASSERT(a_accept_to_check, clk, rst_n, accept |=> state_reg == ST_CHECK)
    `SAE_ASSERT(a_result_holds, clk, rst_n, result_wait |=> state_reg == ST_RESULT)

endmodule

@@ rtl/core/sae_datapath.sv @@
// ---------------------------------------------------------------------------
// sae_datapath
// row and edge memories, walk registers, edge count and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_adjacency_edge_insert_macros.svh"

module sae_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  sae_pkg::cmd_t     cmd,
    output sae_pkg::status_t  status,
    input  logic              func,
    input  logic [7:0]        from_node,
    input  logic [7:0]        to_node,
    input  logic signed [31:0] edge_label,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [9:0]        edge_index,
    output logic              was_duplicate,
    output logic              store_full,
    output logic [10:0]       edge_total
);
    import sae_pkg::*;

    // memories
    edge_idx_t tail_mem   [NODE_COUNT];
    col_t      column_mem [EDGE_CAPACITY];
    edge_idx_t link_mem   [EDGE_CAPACITY];
    label_t    value_mem  [EDGE_CAPACITY];

    logic [NODE_COUNT-1:0] nonempty_reg;
    count_t    count_reg;
    logic      out_valid_reg;
    logic      append_reg;

    logic      func_reg;
    node_t     row_reg;
    col_t      col_reg;
    label_t    label_reg;
    edge_idx_t tail_rd, link_rd;
    col_t      col_rd;
    label_t    value_rd;
    edge_idx_t prev_reg, cur_reg, next_reg, idx_reg;
    logic      dup_reg, full_reg;
    edge_idx_t out_index_reg;
    logic      out_dup_reg, out_full_reg;
    count_t    out_total_reg;

    edge_idx_t new_idx;
    edge_idx_t edge_rd_addr;
    logic      edge_rd_en;
    logic      link_we, tail_we, column_we, value_we;
    edge_idx_t link_wa, value_wa;
    edge_idx_t link_wd;
    label_t    value_wd;

    assign new_idx      = count_reg[EDGE_W-1:0];
    assign edge_rd_addr = cmd.set_tail ? tail_rd : link_rd;
    assign edge_rd_en   = cmd.set_tail | cmd.walk_read;

    assign link_we   = cmd.new_row | cmd.write_new | cmd.write_prev;
    assign link_wa   = cmd.write_prev ? prev_reg : new_idx;
    assign link_wd   = (cmd.write_prev || cmd.new_row) ? new_idx : next_reg;
    assign tail_we   = cmd.new_row | (cmd.write_prev & append_reg);
    assign column_we = cmd.new_row | cmd.write_new;
    assign value_we  = cmd.new_row | cmd.write_new | cmd.merge;
    assign value_wa  = cmd.merge ? cur_reg : new_idx;
    assign value_wd  = cmd.merge ? label_t'(value_rd + label_reg) : label_reg;

    assign status.full     = count_reg >= count_t'(EDGE_CAPACITY);
    assign status.nonempty = nonempty_reg[row_reg];
    assign status.ordered  = func_reg;
    assign status.col_gt   = col_reg > col_rd;
    assign status.col_lt   = col_reg < col_rd;
    assign status.col_eq   = col_reg == col_rd;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_tail)
            tail_rd <= tail_mem[row_reg];
        if (tail_we)
            tail_mem[row_reg] <= new_idx;
    end

    always_ff @(posedge clk)
    begin
        if (edge_rd_en)
        begin
            col_rd   <= column_mem[edge_rd_addr];
            link_rd  <= link_mem[edge_rd_addr];
            value_rd <= value_mem[edge_rd_addr];
        end
        if (column_we)
            column_mem[new_idx] <= col_reg;
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (value_we)
            value_mem[value_wa] <= value_wd;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            append_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.new_row)
                nonempty_reg[row_reg] <= 1'b1;
            if (cmd.new_row || cmd.write_prev)
                count_reg <= count_reg + count_t'(1);
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.load_item)
                append_reg <= 1'b0;
            else if (cmd.take_link)
                append_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg  <= func;
            row_reg   <= from_node;
            col_reg   <= to_node;
            label_reg <= edge_label;
            dup_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end
        if (cmd.set_full)
        begin
            full_reg <= 1'b1;
            idx_reg  <= '0;
        end
        if (cmd.new_row || cmd.write_prev)
            idx_reg <= new_idx;
        if (cmd.set_tail)
            prev_reg <= tail_rd;
        if (cmd.advance)
            prev_reg <= cur_reg;
        if (cmd.walk_read)
            cur_reg <= link_rd;
        if (cmd.take_link)
            next_reg <= link_rd;
        if (cmd.take_cur)
            next_reg <= cur_reg;
        if (cmd.merge)
        begin
            idx_reg <= cur_reg;
            dup_reg <= 1'b1;
        end
        if (cmd.emit)
        begin
            out_index_reg <= idx_reg;
            out_dup_reg   <= dup_reg;
            out_full_reg  <= full_reg;
            out_total_reg <= count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign edge_index    = out_index_reg;
    assign was_duplicate = out_dup_reg;
    assign store_full    = out_full_reg;
    assign edge_total    = out_total_reg;

    `SAE_ASSERT(a_count_bound, clk, rst_n, count_reg <= count_t'(EDGE_CAPACITY))
    `SAE_ASSERT(a_emit_slot_free, clk, rst_n, cmd.emit |-> status.out_free)

endmodule

@@ rtl/core/sparse_adjacency_edge_insert.sv @@
// ---------------------------------------------------------------------------
// sparse_adjacency_edge_insert
// labeled sparse adjacency table builder over linked row lists
// ---------------------------------------------------------------------------
// Each beat on the input side adds one labeled edge from_node -> to_node and
// returns one result beat. Every row is a circular linked list through a
// 1024-entry edge store, with the row's tail pointer kept in a 256-entry
// table; func 0 appends after the tail, func 1 keeps the row in ascending
// column order and, on a matching column, adds the label into the existing
// edge (wrapping at 32 bits) and reports was_duplicate. When all 1024 slots
// are used every item is dropped with store_full set. One item is in work at
// a time, from the accepting edge to the result edge. A dropped item or a
// row's first edge goes from check to result; an append or an ordered
// insert past the tail reads the tail, writes the new edge and relinks prev;
// an inside ordered insert or a merge walks the row first. The walk reads
// one edge per cycle through the registered read port of the edge store,
// so walking inserts follow the row degree. The result register lets the
// next item be accepted while a result is still stalled; a new result only
// waits when that register is still held. Memories need no clearing after
// reset: only the row valid bits, the edge count and control state reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_adjacency_edge_insert
(
    input  logic               clk,
    input  logic               rst_n,
    // input beat
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [7:0]         from_node,
    input  logic [7:0]         to_node,
    input  logic signed [31:0] edge_label,
    // result beat
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         edge_index,
    output logic               was_duplicate,
    output logic               store_full,
    output logic [10:0]        edge_total
);
    import sae_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: decides each step from the datapath status flags
    sae_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // memories, walk pointers and the result register
    sae_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (func),
        .from_node     (from_node),
        .to_node       (to_node),
        .edge_label    (edge_label),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .edge_index    (edge_index),
        .was_duplicate (was_duplicate),
        .store_full    (store_full),
        .edge_total    (edge_total)
    );

endmodule
